[rtl/core/max_pool_2d_stream_top_defines.svh]
// Assertion macros shared by the max pooling RTL.
// No dependencies; the including module supplies clk and arst_n.
`ifndef MAX_POOL_2D_STREAM_TOP_DEFINES_SVH
`define MAX_POOL_2D_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MP2D_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MP2D_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mp2d_pkg.sv]
// Shared types, constants and helper functions of the max pooling block.
// No dependencies.
package mp2d_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_KERNEL = 8;
	localparam int LINES      = MAX_KERNEL - 1;
	localparam int SAMPLE_W   = 16;
	localparam int IDX_W      = 10;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int SLOT_W     = $clog2(LINES);
	localparam int PAD_MAX    = 4;
	localparam int NJ         = PAD_MAX + 1;
	localparam int JW         = $clog2(NJ);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef sample_t [MAX_KERNEL-1:0] col_t;

	localparam sample_t PAD_VALUE = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Windows completed along one axis by the current sample
	typedef struct packed {
		logic [NJ-1:0]    mask;
		logic [NJ-1:0]    fin;
		logic [IDX_W-1:0] base;
	} axis_info_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_MAX,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		REG_IN_HEIGHT,
		REG_IN_WIDTH,
		REG_POOL_HEIGHT,
		REG_POOL_WIDTH,
		REG_STEP_ROWS,
		REG_STEP_COLS,
		REG_PAD_ROWS,
		REG_PAD_COLS
	} reg_idx_t;

	// True when v is s times a whole number from 0 to 18
	function automatic logic is_multiple(input logic [4:0] v, input logic [3:0] s);
		logic       res;
		logic [8:0] prod;
		res = 1'b0;
		for (int m = 0; m < 19; m++) begin
			prod = 9'(m) * {5'b0, s};
			if (prod == {4'b0, v}) res = 1'b1;
		end
		return res;
	endfunction

	// Lowest set bit at or above start: {found, position}
	function automatic logic [JW:0] find_bit(input logic [NJ-1:0] mask,
			input logic [JW:0] start);
		logic [JW:0] res;
		res = '0;
		for (int j = NJ - 1; j >= 0; j--) begin
			if (mask[j] && (JW'(j) >= start[JW-1:0] || start[JW] == 1'b0 && 1'b0)
					&& ((JW+1)'(j) >= start))
				res = {1'b1, JW'(j)};
		end
		return res;
	endfunction

	// Set bits of mask below position pos
	function automatic logic [JW-1:0] count_below(input logic [NJ-1:0] mask,
			input logic [JW-1:0] pos);
		logic [JW-1:0] cnt;
		cnt = '0;
		for (int j = 0; j < NJ; j++) begin
			if (mask[j] && JW'(j) < pos) cnt = cnt + 1'b1;
		end
		return cnt;
	endfunction

	// Line slot that holds the row k rows above the current one
	function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
			input logic [SLOT_W-1:0] k);
		logic [SLOT_W:0] s;
		s = {1'b0, slot} + (SLOT_W+1)'(LINES) - {1'b0, k};
		if (s >= (SLOT_W+1)'(LINES)) s = s - (SLOT_W+1)'(LINES);
		return s[SLOT_W-1:0];
	endfunction

endpackage

[rtl/core/mp2d_axis.sv]
// Position tracker for one axis: index, stride phase and completed windows.
// Depends on mp2d_pkg.
module mp2d_axis (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic                 advance,
	input  logic [10:0]          n,
	input  logic [3:0]           k,
	input  logic [3:0]           step,
	input  logic [2:0]           pad,
	output logic [9:0]           idx,
	output logic                 last,
	output mp2d_pkg::axis_info_t info
);
	import mp2d_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  next_q;
	logic [3:0]        ph_q;
	logic signed [11:0] t;
	logic              hit0;

	// Window-end offset of the current index; a window ends where t is a stride multiple
	assign t    = $signed({2'b00, idx_q}) + $signed({9'b0, pad}) - $signed({8'b0, k}) + 12'sd1;
	assign last = ({1'b0, idx_q} == n - 11'd1);
	assign hit0 = !t[11] && (ph_q == 4'd0);
	assign idx  = idx_q;

	// List windows ended here; the last index also ends those running into padding
	always_comb begin
		logic signed [11:0] u;
		logic [4:0]         v;
		info.base = next_q;
		for (int j = 0; j < NJ; j++) begin
			u = t + 12'(j);
			v = t[11] ? u[4:0] : ({1'b0, ph_q} + 5'(j));
			info.mask[j] = !u[11] && (3'(j) <= pad) && (last || j == 0)
				&& is_multiple(v, step);
			info.fin[j]  = ({2'b0, idx_q} + 12'(j) + 12'd1 + {8'b0, step})
				> ({1'b0, n} + {9'b0, pad});
		end
	end

	// Advance position and stride phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			ph_q   <= '0;
			next_q <= '0;
		end else if (restart) begin
			idx_q  <= '0;
			ph_q   <= '0;
			next_q <= '0;
		end else if (advance) begin
			if (last) begin
				idx_q  <= '0;
				ph_q   <= '0;
				next_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (!t[11]) begin
					ph_q   <= (ph_q == step - 4'd1) ? 4'd0 : ph_q + 4'd1;
					next_q <= next_q + IDX_W'(hit0);
				end
			end
		end
	end

endmodule

[rtl/core/mp2d_linebuf.sv]
// Line store: the last rows of the plane, one word per column holding every line.
// Depends on mp2d_pkg.
module mp2d_linebuf (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [mp2d_pkg::ADDR_W-1:0]   rd_addr,
	input  logic                          wr_en,
	input  mp2d_pkg::sample_t             px,
	input  logic [mp2d_pkg::SLOT_W-1:0]   slot,
	input  logic [mp2d_pkg::IDX_W-1:0]    row,
	output mp2d_pkg::col_t                col
);
	import mp2d_pkg::*;

	localparam int WORD_W = LINES * SAMPLE_W;

	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] wr_word;

	// Read the column word when a beat is taken
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q   <= mem[rd_addr];
			addr_q <= rd_addr;
		end
	end

	// Replace the oldest line of that column with the new sample
	always_comb begin
		for (int s = 0; s < LINES; s++) begin
			wr_word[s*SAMPLE_W +: SAMPLE_W] = (SLOT_W'(s) == slot) ? px
				: rd_q[s*SAMPLE_W +: SAMPLE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr_q] <= wr_word;
	end

	// Assemble the column, rows above the plane top read as padding
	always_comb begin
		logic [SLOT_W-1:0] sl;
		col[0] = px;
		for (int kk = 1; kk < MAX_KERNEL; kk++) begin
			sl = slot_back(slot, SLOT_W'(kk));
			col[kk] = (IDX_W'(kk) <= row) ? rd_q[sl*SAMPLE_W +: SAMPLE_W] : PAD_VALUE;
		end
	end

endmodule

[rtl/core/mp2d_cell.sv]
// One column cell of the window chain: holds a column, gives its masked maximum.
// Depends on mp2d_pkg.
module mp2d_cell (
	input  logic              clk,
	input  logic              shift_en,
	input  logic              cap_en,
	input  mp2d_pkg::col_t    col_in,
	input  logic [3:0]        rlim,
	output mp2d_pkg::col_t    col_out,
	output mp2d_pkg::sample_t colmax
);
	import mp2d_pkg::*;

	col_t    col_q;
	sample_t colmax_q;
	sample_t m;

	// Take the neighbor's column
	always_ff @(posedge clk) begin
		if (shift_en) col_q <= col_in;
	end

	// Maximum over the newest rlim rows
	always_comb begin
		m = PAD_VALUE;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			if (4'(i) < rlim && col_q[i] > m) m = col_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cap_en) colmax_q <= m;
	end

	assign col_out = col_q;
	assign colmax  = colmax_q;

endmodule

[rtl/core/max_pool_2d_stream_top.sv]
// Streaming 2-D max pooling over one plane of Q8.8 samples.
// Depends on mp2d_pkg, mp2d_axis, mp2d_linebuf, mp2d_cell and the defines header.
//
// Usage: samples of a plane enter on pixel/pixel_valid in raster order, planes back
// to back. Each pooling window yields one beat on result_valid carrying pool_max,
// out_row, out_col, last_of_run (last beat caused by that sample) and last_of_plane.
// Geometry is set over the APB port (registers at byte address 4*index) while idle;
// any write restarts the plane at row 0, column 0. With an invalid geometry samples
// are taken and dropped.
// A sample is taken and loaded into the window chain in the next cycle, as the line
// store read returns; a sample ending no window then goes back to idle. Each row of
// windows it ends passes through a step that reduces the column cells, and each
// window through a step that combines cells into the output register. The line
// store is one 1024-word memory read and written once per sample. Reset clears the
// position counters and the output valid flag and sets the registers to their reset
// values. A stalled result holds in the output register; the next sample is still
// taken and loaded behind it, and window work waits for the register.
`include "max_pool_2d_stream_top_defines.svh"

module max_pool_2d_stream_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic signed [15:0]   pixel,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	output logic signed [15:0]   pool_max,
	output logic [9:0]           out_row,
	output logic [9:0]           out_col,
	output logic                 last_of_run,
	output logic                 last_of_plane,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import mp2d_pkg::*;

	// Configuration registers
	logic [10:0] in_height_q, in_width_q;
	logic [3:0]  pool_height_q, pool_width_q, step_rows_q, step_cols_q;
	logic [2:0]  pad_rows_q, pad_cols_q;
	logic        cfg_wr;
	reg_idx_t    reg_idx;
	logic        cfg_ok;

	state_t state_q, state_d;
	logic   accept, go, load_en, cap_en, emit_st, emit_fire;

	sample_t          px_q;
	axis_info_t       rinfo_q, cinfo_q, rinfo, cinfo;
	logic [IDX_W-1:0] cidx_q, row_idx, col_idx;
	logic             row_last, col_last;
	logic [JW-1:0]    jr_q, jc_q;
	logic [SLOT_W-1:0] slot_q;

	col_t    new_col;
	col_t    chain [MAX_KERNEL+1];
	sample_t colmax [MAX_KERNEL];
	logic [3:0] rlim, clim;
	sample_t win_max;

	logic [JW:0] nc, nr, fc, fr;
	logic        run_end;

	logic             out_valid_q;
	sample_t          pool_max_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic             last_of_run_q, last_of_plane_q;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= 11'd1;
			in_width_q    <= 11'd1;
			pool_height_q <= 4'd2;
			pool_width_q  <= 4'd2;
			step_rows_q   <= 4'd2;
			step_cols_q   <= 4'd2;
			pad_rows_q    <= 3'd0;
			pad_cols_q    <= 3'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IN_HEIGHT:   in_height_q   <= pwdata[10:0];
				REG_IN_WIDTH:    in_width_q    <= pwdata[10:0];
				REG_POOL_HEIGHT: pool_height_q <= pwdata[3:0];
				REG_POOL_WIDTH:  pool_width_q  <= pwdata[3:0];
				REG_STEP_ROWS:   step_rows_q   <= pwdata[3:0];
				REG_STEP_COLS:   step_cols_q   <= pwdata[3:0];
				REG_PAD_ROWS:    pad_rows_q    <= pwdata[2:0];
				REG_PAD_COLS:    pad_cols_q    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IN_HEIGHT:   prdata = 32'(in_height_q);
			REG_IN_WIDTH:    prdata = 32'(in_width_q);
			REG_POOL_HEIGHT: prdata = 32'(pool_height_q);
			REG_POOL_WIDTH:  prdata = 32'(pool_width_q);
			REG_STEP_ROWS:   prdata = 32'(step_rows_q);
			REG_STEP_COLS:   prdata = 32'(step_cols_q);
			REG_PAD_ROWS:    prdata = 32'(pad_rows_q);
			REG_PAD_COLS:    prdata = 32'(pad_cols_q);
			default:         prdata = '0;
		endcase
	end

	// Geometry check; samples are dropped while it fails
	assign cfg_ok = (in_height_q >= 11'd1) && (in_height_q <= 11'd1024)
		&& (in_width_q >= 11'd1) && (in_width_q <= 11'(MAX_WIDTH))
		&& (pool_height_q >= 4'd1) && (pool_height_q <= 4'(MAX_KERNEL))
		&& (pool_width_q >= 4'd1) && (pool_width_q <= 4'(MAX_KERNEL))
		&& (step_rows_q != 4'd0) && (step_cols_q != 4'd0)
		&& (pad_rows_q <= 3'(PAD_MAX)) && (pad_cols_q <= 3'(PAD_MAX))
		&& ({1'b0, pad_rows_q, 1'b0} <= {1'b0, pool_height_q})
		&& ({1'b0, pad_cols_q, 1'b0} <= {1'b0, pool_width_q})
		&& ({1'b0, in_height_q} + {8'b0, pad_rows_q, 1'b0} >= {8'b0, pool_height_q})
		&& ({1'b0, in_width_q} + {8'b0, pad_cols_q, 1'b0} >= {8'b0, pool_width_q});

	// Position trackers
	mp2d_axis u_col_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.advance (load_en),
		.n       (in_width_q),
		.k       (pool_width_q),
		.step    (step_cols_q),
		.pad     (pad_cols_q),
		.idx     (col_idx),
		.last    (col_last),
		.info    (cinfo)
	);

	mp2d_axis u_row_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.advance (load_en && col_last),
		.n       (in_height_q),
		.k       (pool_height_q),
		.step    (step_rows_q),
		.pad     (pad_rows_q),
		.idx     (row_idx),
		.last    (row_last),
		.info    (rinfo)
	);

	// Line slot of the current row, modulo the line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cfg_wr) begin
			slot_q <= '0;
		end else if (load_en && col_last) begin
			if (row_last || slot_q == SLOT_W'(LINES - 1)) slot_q <= '0;
			else slot_q <= slot_q + 1'b1;
		end
	end

	// Capture the beat and what it completes
	assign accept = pixel_valid && !pixel_stall;
	assign go     = accept && cfg_ok;

	always_ff @(posedge clk) begin
		if (go) begin
			px_q    <= pixel;
			rinfo_q <= rinfo;
			cinfo_q <= cinfo;
			cidx_q  <= col_idx;
		end
	end

	mp2d_linebuf u_linebuf (
		.clk     (clk),
		.rd_en   (go),
		.rd_addr (ADDR_W'(col_idx)),
		.wr_en   (load_en),
		.px      (px_q),
		.slot    (slot_q),
		.row     (row_idx),
		.col     (new_col)
	);

	// Window chain: cell i holds the column i places to the left
	assign chain[0] = new_col;
	assign rlim = pool_height_q - {1'b0, jr_q};
	assign clim = pool_width_q - {1'b0, jc_q};

	for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_cell
		mp2d_cell u_cell (
			.clk      (clk),
			.shift_en (load_en),
			.cap_en   (cap_en),
			.col_in   (chain[g]),
			.rlim     (rlim),
			.col_out  (chain[g+1]),
			.colmax   (colmax[g])
		);
	end

	// Combine the cells inside the window, left of the plane edge excluded
	always_comb begin
		win_max = PAD_VALUE;
		for (int a = 0; a < MAX_KERNEL; a++) begin
			if (4'(a) < clim && IDX_W'(a) <= cidx_q && colmax[a] > win_max)
				win_max = colmax[a];
		end
	end

	// Window iteration
	assign nc = find_bit(cinfo_q.mask, {1'b0, jc_q} + 1'b1);
	assign nr = find_bit(rinfo_q.mask, {1'b0, jr_q} + 1'b1);
	assign fc = find_bit(cinfo_q.mask, '0);
	assign fr = find_bit(rinfo_q.mask, '0);
	assign run_end   = !nc[JW] && !nr[JW];
	assign emit_fire = emit_st && (!out_valid_q || !result_stall);

	always_ff @(posedge clk) begin
		if (load_en) begin
			jr_q <= fr[JW-1:0];
			jc_q <= fc[JW-1:0];
		end else if (emit_fire) begin
			if (nc[JW]) begin
				jc_q <= nc[JW-1:0];
			end else if (nr[JW]) begin
				jr_q <= nr[JW-1:0];
				jc_q <= fc[JW-1:0];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (go) state_d = S_LOAD;
			S_LOAD: begin
				if ((|rinfo_q.mask) && (|cinfo_q.mask)) state_d = S_MAX;
				else state_d = S_IDLE;
			end
			S_MAX:  state_d = S_EMIT;
			S_EMIT: begin
				if (emit_fire) begin
					if (nc[JW]) state_d = S_EMIT;
					else if (nr[JW]) state_d = S_MAX;
					else state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pixel_stall = 1'b1;
		load_en     = 1'b0;
		cap_en      = 1'b0;
		emit_st     = 1'b0;
		case (state_q)
			S_IDLE:  pixel_stall = 1'b0;
			S_LOAD:  load_en = 1'b1;
			S_MAX:   cap_en = 1'b1;
			S_EMIT:  emit_st = 1'b1;
			default: pixel_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Output register: load a window, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pool_max_q      <= win_max;
			out_row_q       <= rinfo_q.base + IDX_W'(count_below(rinfo_q.mask, jr_q));
			out_col_q       <= cinfo_q.base + IDX_W'(count_below(cinfo_q.mask, jc_q));
			last_of_run_q   <= run_end;
			last_of_plane_q <= rinfo_q.fin[jr_q] && cinfo_q.fin[jc_q];
		end
	end

	assign result_valid  = out_valid_q;
	assign pool_max      = pool_max_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign last_of_run   = last_of_run_q;
	assign last_of_plane = last_of_plane_q;

	`MP2D_ASSERT_NEXT(a_go_loads, go, state_q == S_LOAD, "accepted beat not loaded")
	`MP2D_ASSERT_IMP(a_emit_has_windows, state_q == S_EMIT, (|rinfo_q.mask) && (|cinfo_q.mask), "emit without windows")
	`MP2D_ASSERT_IMP(a_plane_ends_run, out_valid_q && last_of_plane_q, last_of_run_q, "plane end not run end")
	`MP2D_ASSERT_NEXT(a_fire_valid, emit_fire, out_valid_q, "loaded result not valid")

endmodule
